### src/dcve_pkg.sv
package dcve_pkg;

    // Widths of the datapath
    localparam int unsigned VEL_W        = 32;
    localparam int unsigned RAD_W        = 31;
    localparam int unsigned DIFF_W       = VEL_W + 1;
    localparam int unsigned MAG_W        = VEL_W;
    localparam int unsigned PROD_W       = 2 * MAG_W;
    localparam int unsigned DEN_W        = PROD_W + 1;
    localparam int unsigned Q_W          = MAG_W + 1;
    localparam int unsigned NUM_W        = DEN_W + Q_W;
    localparam int unsigned DELTA_W      = Q_W + 2;

    // Pipeline depth
    localparam int unsigned FRONT_STAGES = 5;
    localparam int unsigned DIV_STAGES   = Q_W;
    localparam int unsigned BACK_STAGES  = 1;
    localparam int unsigned NUM_STAGES   = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

    typedef logic signed [VEL_W-1:0] t_vel;

    typedef struct packed {
        t_vel             first_pos_x;
        t_vel             first_pos_y;
        t_vel             second_pos_x;
        t_vel             second_pos_y;
        t_vel             first_vel_x;
        t_vel             first_vel_y;
        t_vel             second_vel_x;
        t_vel             second_vel_y;
        logic [RAD_W-1:0] first_radius;
        logic [RAD_W-1:0] second_radius;
    } t_pair;

    typedef struct packed {
        t_vel v1x;
        t_vel v1y;
        t_vel v2x;
        t_vel v2y;
    } t_vels;

    typedef struct packed {
        logic hit;
        logic degen;
        logic neg_x;
        logic neg_y;
    } t_flags;

    typedef struct packed {
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] num_x;
        logic [NUM_W-1:0] num_y;
        t_flags           flags;
        t_vels            vels;
    } t_div_in;

    typedef struct packed {
        logic [Q_W-1:0] q_x;
        logic [Q_W-1:0] q_y;
        t_flags         flags;
        t_vels          vels;
    } t_div_out;

    // Magnitude of a difference of two 32-bit values; always fits 32 bits
    function automatic logic [MAG_W-1:0] mag(input logic [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] a;
        a = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
        return a[MAG_W-1:0];
    endfunction

    // Clamp a wide signed sum to 32 signed bits
    function automatic t_vel sat(input logic [DELTA_W-1:0] v);
        t_vel r;
        if (v[DELTA_W-1] && !(&v[DELTA_W-2:VEL_W-1])) begin
            r = {1'b1, {(VEL_W-1){1'b0}}};
        end else if (!v[DELTA_W-1] && (|v[DELTA_W-2:VEL_W-1])) begin
            r = {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/dcve_if.sv
interface dcve_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [dcve_pkg::VEL_W-1:0]   first_pos_x;
    logic signed [dcve_pkg::VEL_W-1:0]   first_pos_y;
    logic signed [dcve_pkg::VEL_W-1:0]   second_pos_x;
    logic signed [dcve_pkg::VEL_W-1:0]   second_pos_y;
    logic signed [dcve_pkg::VEL_W-1:0]   first_vel_x;
    logic signed [dcve_pkg::VEL_W-1:0]   first_vel_y;
    logic signed [dcve_pkg::VEL_W-1:0]   second_vel_x;
    logic signed [dcve_pkg::VEL_W-1:0]   second_vel_y;
    logic [dcve_pkg::RAD_W-1:0]          first_radius;
    logic [dcve_pkg::RAD_W-1:0]          second_radius;

    modport source (
        output valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
               first_vel_x, first_vel_y, second_vel_x, second_vel_y,
               first_radius, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
               first_vel_x, first_vel_y, second_vel_x, second_vel_y,
               first_radius, second_radius,
        output ready
    );
endinterface

interface dcve_out_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic                                degenerate;
    logic signed [dcve_pkg::VEL_W-1:0]   new_first_vel_x;
    logic signed [dcve_pkg::VEL_W-1:0]   new_first_vel_y;
    logic signed [dcve_pkg::VEL_W-1:0]   new_second_vel_x;
    logic signed [dcve_pkg::VEL_W-1:0]   new_second_vel_y;

    modport source (
        output valid, hit, degenerate, new_first_vel_x, new_first_vel_y,
               new_second_vel_x, new_second_vel_y,
        input  ready
    );
    modport sink (
        input  valid, hit, degenerate, new_first_vel_x, new_first_vel_y,
               new_second_vel_x, new_second_vel_y,
        output ready
    );
endinterface

### src/disc_collision_velocity_exchange_top.sv
// Disc pair collision with equal-mass elastic velocity exchange.
// i_pair (sink) takes one pair of discs per item: positions, velocities and
// radii in Q16.16. o_res (source) gives one result item per input item, in
// order: hit, degenerate and the four new velocities, saturated to 32 bits.
// An item moves when valid and ready are both high.
// Throughput: one item per cycle, unless a stalled receiver has filled all stages.
// Five front stages form the products, the exact division takes one quotient
// bit per stage over 33 stages, and the last stage applies the exchange and
// saturation.
// Every stage carries a valid bit; a stage loads whenever it or any stage
// after it is empty, so a stalled receiver only stops the input once all
// 39 stages hold items. Nothing is lost or repeated while stalled.
// Reset (i_rst_n low, synchronous) clears all valid bits; the data registers are
// not reset, and there is no configuration.
module disc_collision_velocity_exchange_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcve_in_if.sink    i_pair,
    dcve_out_if.source o_res
);

    localparam int unsigned NS = dcve_pkg::NUM_STAGES;
    localparam int unsigned FS = dcve_pkg::FRONT_STAGES;
    localparam int unsigned DS = dcve_pkg::DIV_STAGES;

    logic [NS-1:0]       r_v;
    logic [NS-1:0]       n_v;
    logic [NS-1:0]       load;
    dcve_pkg::t_pair     pair;
    dcve_pkg::t_div_in   div_in;
    dcve_pkg::t_div_out  div_out;
    dcve_pkg::t_vels     res_vels;
    logic                acc_in, acc_out;

    // A stage loads unless it and every later stage are full and stalled
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            load[k] = o_res.ready || !(&(r_v | ~({NS{1'b1}} << k)));
        end
    end

    // Advance valid bits along with the data
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (load[k]) begin
                n_v[k] = (k == 0) ? i_pair.valid : r_v[(k == 0) ? 0 : k - 1];
            end else begin
                n_v[k] = r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign i_pair.ready = load[0];
    assign acc_in       = i_pair.valid && i_pair.ready;
    assign acc_out      = o_res.valid && o_res.ready;

    assign pair = '{first_pos_x:  i_pair.first_pos_x,  first_pos_y:  i_pair.first_pos_y,
                    second_pos_x: i_pair.second_pos_x, second_pos_y: i_pair.second_pos_y,
                    first_vel_x:  i_pair.first_vel_x,  first_vel_y:  i_pair.first_vel_y,
                    second_vel_x: i_pair.second_vel_x, second_vel_y: i_pair.second_vel_y,
                    first_radius: i_pair.first_radius,
                    second_radius: i_pair.second_radius};

    dcve_front u_front (
        .i_clk  (i_clk),
        .i_load (load[FS-1:0]),
        .i_pair (pair),
        .o_div  (div_in)
    );

    dcve_div u_div (
        .i_clk  (i_clk),
        .i_load (load[FS+DS-1:FS]),
        .i_div  (div_in),
        .o_div  (div_out)
    );

    dcve_back u_back (
        .i_clk        (i_clk),
        .i_load       (load[NS-1]),
        .i_div        (div_out),
        .o_hit        (o_res.hit),
        .o_degenerate (o_res.degenerate),
        .o_vels       (res_vels)
    );

    assign o_res.valid            = r_v[NS-1];
    assign o_res.new_first_vel_x  = res_vels.v1x;
    assign o_res.new_first_vel_y  = res_vels.v1y;
    assign o_res.new_second_vel_x = res_vels.v2x;
    assign o_res.new_second_vel_y = res_vels.v2y;

`ifndef NO_ASSERTIONS
    a_degen_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.hit || !o_res.degenerate))
        else $error("degenerate result without contact");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pair.ready |-> (o_res.valid && !o_res.ready && (&r_v)))
        else $error("input stalled while the pipeline has a free stage");

    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_v) == $past($countones(r_v))
                  + int'($past(acc_in)) - int'($past(acc_out))))
        else $error("items lost or repeated in the pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result offered straight after reset");
`endif

endmodule

### src/dcve_front.sv
module dcve_front (
    input  logic                                   i_clk,
    input  logic [dcve_pkg::FRONT_STAGES-1:0]      i_load,
    input  dcve_pkg::t_pair                        i_pair,
    output dcve_pkg::t_div_in                      o_div
);

    // Stage A: differences and radius sum
    logic [dcve_pkg::DIFF_W-1:0]  r_a_dx, r_a_dy, r_a_dvx, r_a_dvy;
    logic [dcve_pkg::MAG_W-1:0]   r_a_rsum;
    dcve_pkg::t_vels              r_a_vels;

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_a_dx   <= {i_pair.first_pos_x[dcve_pkg::VEL_W-1], i_pair.first_pos_x}
                      - {i_pair.second_pos_x[dcve_pkg::VEL_W-1], i_pair.second_pos_x};
            r_a_dy   <= {i_pair.first_pos_y[dcve_pkg::VEL_W-1], i_pair.first_pos_y}
                      - {i_pair.second_pos_y[dcve_pkg::VEL_W-1], i_pair.second_pos_y};
            r_a_dvx  <= {i_pair.second_vel_x[dcve_pkg::VEL_W-1], i_pair.second_vel_x}
                      - {i_pair.first_vel_x[dcve_pkg::VEL_W-1], i_pair.first_vel_x};
            r_a_dvy  <= {i_pair.second_vel_y[dcve_pkg::VEL_W-1], i_pair.second_vel_y}
                      - {i_pair.first_vel_y[dcve_pkg::VEL_W-1], i_pair.first_vel_y};
            r_a_rsum <= {1'b0, i_pair.first_radius} + {1'b0, i_pair.second_radius};
            r_a_vels <= '{v1x: i_pair.first_vel_x,  v1y: i_pair.first_vel_y,
                          v2x: i_pair.second_vel_x, v2y: i_pair.second_vel_y};
        end
    end

    // Stage B: the five products, three squares and two cross products
    logic [dcve_pkg::MAG_W-1:0]   m_dx, m_dy, m_dvx, m_dvy;
    logic [dcve_pkg::MAG_W-1:0]   r_b_mdx, r_b_mdy;
    logic [dcve_pkg::PROD_W-1:0]  r_b_dxx, r_b_dyy, r_b_lim, r_b_px, r_b_py;
    logic                         r_b_nx, r_b_ny, r_b_sx, r_b_sy, r_b_degen;
    dcve_pkg::t_vels              r_b_vels;

    assign m_dx  = dcve_pkg::mag(r_a_dx);
    assign m_dy  = dcve_pkg::mag(r_a_dy);
    assign m_dvx = dcve_pkg::mag(r_a_dvx);
    assign m_dvy = dcve_pkg::mag(r_a_dvy);

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_b_mdx   <= m_dx;
            r_b_mdy   <= m_dy;
            r_b_dxx   <= m_dx * m_dx;
            r_b_dyy   <= m_dy * m_dy;
            r_b_lim   <= r_a_rsum * r_a_rsum;
            r_b_px    <= m_dvx * m_dx;
            r_b_py    <= m_dvy * m_dy;
            r_b_nx    <= r_a_dvx[dcve_pkg::DIFF_W-1] ^ r_a_dx[dcve_pkg::DIFF_W-1];
            r_b_ny    <= r_a_dvy[dcve_pkg::DIFF_W-1] ^ r_a_dy[dcve_pkg::DIFF_W-1];
            r_b_sx    <= r_a_dx[dcve_pkg::DIFF_W-1];
            r_b_sy    <= r_a_dy[dcve_pkg::DIFF_W-1];
            r_b_degen <= (r_a_dx == '0) && (r_a_dy == '0);
            r_b_vels  <= r_a_vels;
        end
    end

    // Stage C: squared distance and signed dot product as magnitude and sign
    logic [dcve_pkg::DEN_W-1:0]   n_c_nmag;
    logic                         n_c_nneg;
    logic [dcve_pkg::DEN_W-1:0]   r_c_den, r_c_nmag;
    logic [dcve_pkg::PROD_W-1:0]  r_c_lim;
    logic [dcve_pkg::MAG_W-1:0]   r_c_mdx, r_c_mdy;
    logic                         r_c_nneg, r_c_sx, r_c_sy, r_c_degen;
    dcve_pkg::t_vels              r_c_vels;

    always_comb begin
        if (r_b_nx == r_b_ny) begin
            n_c_nmag = {1'b0, r_b_px} + {1'b0, r_b_py};
            n_c_nneg = r_b_nx;
        end else if (r_b_px >= r_b_py) begin
            n_c_nmag = {1'b0, r_b_px - r_b_py};
            n_c_nneg = r_b_nx;
        end else begin
            n_c_nmag = {1'b0, r_b_py - r_b_px};
            n_c_nneg = r_b_ny;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_c_den   <= {1'b0, r_b_dxx} + {1'b0, r_b_dyy};
            r_c_nmag  <= n_c_nmag;
            r_c_nneg  <= n_c_nneg;
            r_c_lim   <= r_b_lim;
            r_c_mdx   <= r_b_mdx;
            r_c_mdy   <= r_b_mdy;
            r_c_sx    <= r_b_sx;
            r_c_sy    <= r_b_sy;
            r_c_degen <= r_b_degen;
            r_c_vels  <= r_b_vels;
        end
    end

    // Stage D: contact test and split numerator products
    localparam int unsigned LO_W = dcve_pkg::Q_W;
    localparam int unsigned HI_W = dcve_pkg::DEN_W - LO_W;
    logic [LO_W+dcve_pkg::MAG_W-1:0] r_d_lox, r_d_loy;
    logic [HI_W+dcve_pkg::MAG_W-1:0] r_d_hix, r_d_hiy;
    logic [dcve_pkg::DEN_W-1:0]      r_d_den;
    dcve_pkg::t_flags                r_d_flags;
    dcve_pkg::t_vels                 r_d_vels;

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r_d_lox         <= r_c_nmag[LO_W-1:0] * r_c_mdx;
            r_d_hix         <= r_c_nmag[dcve_pkg::DEN_W-1:LO_W] * r_c_mdx;
            r_d_loy         <= r_c_nmag[LO_W-1:0] * r_c_mdy;
            r_d_hiy         <= r_c_nmag[dcve_pkg::DEN_W-1:LO_W] * r_c_mdy;
            r_d_den         <= r_c_den;
            r_d_flags.hit   <= {1'b0, r_c_lim} >= r_c_den;
            r_d_flags.degen <= r_c_degen;
            r_d_flags.neg_x <= r_c_sx ^ r_c_nneg;
            r_d_flags.neg_y <= r_c_sy ^ r_c_nneg;
            r_d_vels        <= r_c_vels;
        end
    end

    // Stage E: join the partial products
    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            o_div.num_x <= dcve_pkg::NUM_W'({r_d_hix, {LO_W{1'b0}}})
                         + dcve_pkg::NUM_W'(r_d_lox);
            o_div.num_y <= dcve_pkg::NUM_W'({r_d_hiy, {LO_W{1'b0}}})
                         + dcve_pkg::NUM_W'(r_d_loy);
            o_div.den   <= r_d_den;
            o_div.flags <= r_d_flags;
            o_div.vels  <= r_d_vels;
        end
    end

endmodule

### src/dcve_div.sv
module dcve_div (
    input  logic                                 i_clk,
    input  logic [dcve_pkg::DIV_STAGES-1:0]      i_load,
    input  dcve_pkg::t_div_in                    i_div,
    output dcve_pkg::t_div_out                   o_div
);

    typedef struct packed {
        logic [dcve_pkg::DEN_W-1:0] rem_x;
        logic [dcve_pkg::DEN_W-1:0] rem_y;
        logic [dcve_pkg::Q_W-1:0]   low_x;
        logic [dcve_pkg::Q_W-1:0]   low_y;
        logic [dcve_pkg::Q_W-1:0]   q_x;
        logic [dcve_pkg::Q_W-1:0]   q_y;
        logic [dcve_pkg::DEN_W-1:0] den;
        dcve_pkg::t_flags           flags;
        dcve_pkg::t_vels            vels;
    } t_div_stage;

    t_div_stage r_st [dcve_pkg::DIV_STAGES];
    t_div_stage n_st [dcve_pkg::DIV_STAGES];
    t_div_stage head;

    // Quotient is below 2^Q_W, so the upper numerator bits start below den
    always_comb begin
        head.rem_x = i_div.num_x[dcve_pkg::NUM_W-1:dcve_pkg::Q_W];
        head.rem_y = i_div.num_y[dcve_pkg::NUM_W-1:dcve_pkg::Q_W];
        head.low_x = i_div.num_x[dcve_pkg::Q_W-1:0];
        head.low_y = i_div.num_y[dcve_pkg::Q_W-1:0];
        head.q_x   = '0;
        head.q_y   = '0;
        head.den   = i_div.den;
        head.flags = i_div.flags;
        head.vels  = i_div.vels;
    end

    // One restoring step per stage on each axis
    always_comb begin
        t_div_stage               src;
        logic [dcve_pkg::DEN_W:0] tx, ty, dd;
        for (int k = 0; k < dcve_pkg::DIV_STAGES; k++) begin
            src      = (k == 0) ? head : r_st[(k == 0) ? 0 : k - 1];
            n_st[k]  = src;
            dd       = {1'b0, src.den};
            tx       = {src.rem_x, src.low_x[dcve_pkg::Q_W-1]};
            ty       = {src.rem_y, src.low_y[dcve_pkg::Q_W-1]};
            n_st[k].low_x = {src.low_x[dcve_pkg::Q_W-2:0], 1'b0};
            n_st[k].low_y = {src.low_y[dcve_pkg::Q_W-2:0], 1'b0};
            if (tx >= dd) begin
                n_st[k].rem_x = dcve_pkg::DEN_W'(tx - dd);
                n_st[k].q_x   = {src.q_x[dcve_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_st[k].rem_x = tx[dcve_pkg::DEN_W-1:0];
                n_st[k].q_x   = {src.q_x[dcve_pkg::Q_W-2:0], 1'b0};
            end
            if (ty >= dd) begin
                n_st[k].rem_y = dcve_pkg::DEN_W'(ty - dd);
                n_st[k].q_y   = {src.q_y[dcve_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_st[k].rem_y = ty[dcve_pkg::DEN_W-1:0];
                n_st[k].q_y   = {src.q_y[dcve_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // Advance each stage when its slot frees
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < dcve_pkg::DIV_STAGES; k++) begin
            if (i_load[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_div.q_x   = r_st[dcve_pkg::DIV_STAGES-1].q_x;
    assign o_div.q_y   = r_st[dcve_pkg::DIV_STAGES-1].q_y;
    assign o_div.flags = r_st[dcve_pkg::DIV_STAGES-1].flags;
    assign o_div.vels  = r_st[dcve_pkg::DIV_STAGES-1].vels;

endmodule

### src/dcve_back.sv
module dcve_back (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  dcve_pkg::t_div_out           i_div,
    output logic                         o_hit,
    output logic                         o_degenerate,
    output dcve_pkg::t_vels              o_vels
);

    localparam int unsigned DW = dcve_pkg::DELTA_W;

    logic [DW-1:0] ex, ey, s1x, s1y, s2x, s2y;
    logic          act;

    // Signed exchange terms and the widened sums
    always_comb begin
        ex  = i_div.flags.neg_x ? (~DW'(i_div.q_x) + DW'(1)) : DW'(i_div.q_x);
        ey  = i_div.flags.neg_y ? (~DW'(i_div.q_y) + DW'(1)) : DW'(i_div.q_y);
        s1x = DW'(signed'(i_div.vels.v1x)) + ex;
        s1y = DW'(signed'(i_div.vels.v1y)) + ey;
        s2x = DW'(signed'(i_div.vels.v2x)) - ex;
        s2y = DW'(signed'(i_div.vels.v2y)) - ey;
        act = i_div.flags.hit && !i_div.flags.degen;
    end

    // Output register; velocities pass unchanged without a proper contact
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_hit        <= i_div.flags.hit;
            o_degenerate <= i_div.flags.degen;
            if (act) begin
                o_vels.v1x <= dcve_pkg::sat(s1x);
                o_vels.v1y <= dcve_pkg::sat(s1y);
                o_vels.v2x <= dcve_pkg::sat(s2x);
                o_vels.v2y <= dcve_pkg::sat(s2y);
            end else begin
                o_vels <= i_div.vels;
            end
        end
    end

endmodule

### test/disc_collision_velocity_exchange_top_tb.sv
module disc_collision_velocity_exchange_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Expected result of one pair
    typedef struct packed {
        logic           hit;
        logic           degen;
        dcve_pkg::t_vel v1x;
        dcve_pkg::t_vel v1y;
        dcve_pkg::t_vel v2x;
        dcve_pkg::t_vel v2y;
    } t_exchange;

    // Directed row: stimulus plus optional typed-in answer
    typedef struct {
        dcve_pkg::t_pair pair;
        bit              typed;
        t_exchange       want;
    } t_row;

    localparam int unsigned LATENCY     = 40;
    localparam int unsigned RANDOM_PAIRS = 1500;
    localparam longint      CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    dcve_in_if  pair_if ();
    dcve_out_if res_if ();

    disc_collision_velocity_exchange_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair_if.sink),
        .o_res   (res_if.source)
    );

    t_exchange exchange_q[$];
    t_exchange typed_q[$];
    bit        typed_flag_q[$];
    int        fail_count;
    longint    cycle_count;
    bit        stim_done;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Clamp a wide signed value to 32 signed bits
    function automatic dcve_pkg::t_vel clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return dcve_pkg::t_vel'(v[31:0]);
    endfunction

    // Work out hit, degenerate and the exchanged velocities of one pair
    function automatic t_exchange predict_exchange(input dcve_pkg::t_pair p);
        t_exchange r;
        logic signed [127:0] dx, dy, v1x, v1y, v2x, v2y, rsum, dd, lim, dvd;
        logic signed [127:0] ex, ey, ax, ay, nmag;
        dx   = 128'(signed'(p.first_pos_x)) - 128'(signed'(p.second_pos_x));
        dy   = 128'(signed'(p.first_pos_y)) - 128'(signed'(p.second_pos_y));
        v1x  = 128'(signed'(p.first_vel_x));
        v1y  = 128'(signed'(p.first_vel_y));
        v2x  = 128'(signed'(p.second_vel_x));
        v2y  = 128'(signed'(p.second_vel_y));
        rsum = 128'(p.first_radius) + 128'(p.second_radius);
        dd   = dx * dx + dy * dy;
        lim  = rsum * rsum;
        r.hit   = (lim >= dd);
        r.degen = (dx == 0 && dy == 0);
        r.v1x = p.first_vel_x;
        r.v1y = p.first_vel_y;
        r.v2x = p.second_vel_x;
        r.v2y = p.second_vel_y;
        if (r.hit && !r.degen) begin
            dvd  = (v2x - v1x) * dx + (v2y - v1y) * dy;
            nmag = dvd < 0 ? -dvd : dvd;
            // truncate toward zero, cap the magnitude at 2^40
            ax = ((dx < 0 ? -dx : dx) * nmag) / dd;
            ay = ((dy < 0 ? -dy : dy) * nmag) / dd;
            if (ax > (128'sd1 <<< 40)) ax = 128'sd1 <<< 40;
            if (ay > (128'sd1 <<< 40)) ay = 128'sd1 <<< 40;
            ex = ((dx < 0) != (dvd < 0)) ? -ax : ax;
            ey = ((dy < 0) != (dvd < 0)) ? -ay : ay;
            r.v1x = clamp32(v1x + ex);
            r.v1y = clamp32(v1y + ey);
            r.v2x = clamp32(v2x - ex);
            r.v2y = clamp32(v2y - ey);
        end
        return r;
    endfunction

    function automatic dcve_pkg::t_pair make_pair(
            input dcve_pkg::t_vel px1, py1, px2, py2,
            input dcve_pkg::t_vel vx1, vy1, vx2, vy2,
            input logic [dcve_pkg::RAD_W-1:0] r1, r2);
        dcve_pkg::t_pair p;
        p.first_pos_x  = px1;
        p.first_pos_y  = py1;
        p.second_pos_x = px2;
        p.second_pos_y = py2;
        p.first_vel_x  = vx1;
        p.first_vel_y  = vy1;
        p.second_vel_x = vx2;
        p.second_vel_y = vy2;
        p.first_radius  = r1;
        p.second_radius = r2;
        return p;
    endfunction

    // Random value biased toward extremes and small magnitudes
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    // Random pair, mostly with nearby centres
    function automatic dcve_pkg::t_pair rand_pair();
        dcve_pkg::t_pair p;
        logic [31:0] base_x, base_y;
        p = make_pair(rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_word(), rand_word(), rand_word(),
                      31'($urandom), 31'($urandom));
        if ($urandom_range(0, 3) != 0) begin
            // nearby centres with radii around the distance
            base_x = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 1 << 24)));
            base_y = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 1 << 24)));
            p.first_pos_x  = base_x;
            p.first_pos_y  = base_y;
            p.second_pos_x = base_x + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            p.second_pos_y = base_y + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            if ($urandom_range(0, 15) == 0) begin
                p.second_pos_x = base_x;
                p.second_pos_y = base_y;
            end
            p.first_radius  = 31'($urandom_range(0, 1 << 19));
            p.second_radius = 31'($urandom_range(0, 1 << 19));
        end
        return p;
    endfunction

    // Offer one pair until accepted
    task automatic send_pair(input dcve_pkg::t_pair p, input bit typed, input t_exchange want);
        pair_if.valid         <= 1'b1;
        pair_if.first_pos_x   <= p.first_pos_x;
        pair_if.first_pos_y   <= p.first_pos_y;
        pair_if.second_pos_x  <= p.second_pos_x;
        pair_if.second_pos_y  <= p.second_pos_y;
        pair_if.first_vel_x   <= p.first_vel_x;
        pair_if.first_vel_y   <= p.first_vel_y;
        pair_if.second_vel_x  <= p.second_vel_x;
        pair_if.second_vel_y  <= p.second_vel_y;
        pair_if.first_radius  <= p.first_radius;
        pair_if.second_radius <= p.second_radius;
        do @(posedge i_clk); while (!pair_if.ready);
        exchange_q.push_back(predict_exchange(p));
        typed_q.push_back(want);
        typed_flag_q.push_back(typed);
    endtask

    task automatic idle_gap(input int n);
        pair_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_row      rows[$];
        t_row      row;
        t_exchange keep;
        int        burst;
        logic [31:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        stim_done     = 1'b0;
        i_rst_n       = 1'b0;
        pair_if.valid = 1'b0;
        pair_if.first_pos_x  = '0;
        pair_if.first_pos_y  = '0;
        pair_if.second_pos_x = '0;
        pair_if.second_pos_y = '0;
        pair_if.first_vel_x  = '0;
        pair_if.first_vel_y  = '0;
        pair_if.second_vel_x = '0;
        pair_if.second_vel_y = '0;
        pair_if.first_radius  = '0;
        pair_if.second_radius = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coincident centres at zero radius: degenerate, velocities pass
        row.pair = make_pair(0, 0, 0, 0, 5, -7, mx, mn, 0, 0);
        row.typed = 1'b1;
        row.want = '{1'b1, 1'b1, 5, -7, mx, mn};
        rows.push_back(row);
        // Coincident centres at opposite extreme positions of both
        row.pair = make_pair(mn, mx, mn, mx, mn, mx, 1, -1, 31'h7fffffff, 31'h7fffffff);
        row.want = '{1'b1, 1'b1, mn, mx, 1, -1};
        rows.push_back(row);
        // Far apart: no contact
        row.pair = make_pair(mn, mn, mx, mx, 3, 4, -3, -4, 0, 0);
        row.want = '{1'b0, 1'b0, 3, 4, -3, -4};
        rows.push_back(row);
        // Largest distance, largest radii: radius sum falls short
        row.pair = make_pair(mn, mn, mx, mx, mx, mn, mn, mx,
                             31'h7fffffff, 31'h7fffffff);
        row.typed = 1'b0;
        rows.push_back(row);
        // Touching exactly along x: 2.0 apart, radii 1.0 each
        row.pair = make_pair(32'h20000, 0, 0, 0, 0, 0, 32'hfff10000, 0,
                             31'h10000, 31'h10000);
        row.typed = 1'b1;
        row.want = '{1'b1, 1'b0, 32'hfff10000, 0, 0, 0};
        rows.push_back(row);
        // One unit too far
        row.pair = make_pair(32'h20001, 0, 0, 0, 0, 0, 32'hfff10000, 0,
                             31'h10000, 31'h10000);
        row.want = '{1'b0, 1'b0, 0, 0, 32'hfff10000, 0};
        rows.push_back(row);
        // Overlap along y
        row.pair = make_pair(0, 32'h10000, 0, 0, 7, 32'h30000, 9, -2,
                             31'h10000, 31'h10000);
        row.typed = 1'b0;
        rows.push_back(row);
        // Diagonal contact
        row.pair = make_pair(32'h10000, 32'h10000, 0, 0, 32'h5000, -32'sh3000,
                             -32'sh20000, 32'h18000, 31'h20000, 31'h0);
        rows.push_back(row);
        // Extreme opposite velocities along x, along y and on the diagonal
        row.pair = make_pair(1, 0, 0, 0, mx, 0, mn, 0, 31'h1, 31'h1);
        rows.push_back(row);
        row.pair = make_pair(0, 1, 0, 0, 0, mn, 0, mx, 31'h1, 31'h0);
        rows.push_back(row);
        row.pair = make_pair(-1, -1, 0, 0, mn, mx, mx, mn, 31'h2, 31'h2);
        rows.push_back(row);
        // Extreme differences, out of contact
        row.pair = make_pair(mx, 0, mn, 0, mx, mx, mn, mn,
                             31'h7fffffff, 31'h7fffffff);
        rows.push_back(row);
        row.pair = make_pair(mx, mn, mn, mx, mn, mn, mx, mx,
                             31'h7fffffff, 31'h7fffffff);
        rows.push_back(row);
        row.pair = make_pair(mn, 32'h7, mx, -32'sh9, 32'h1234, -32'sh777,
                             32'h55555555, 32'haaaaaaaa, 31'h7fffffff, 31'h7fffffff);
        rows.push_back(row);
        // Alternating bit patterns in most fields
        row.pair = make_pair(32'h55555555, 32'haaaaaaaa, 32'h55555554, 32'haaaaaaab,
                             32'haaaaaaaa, 32'h55555555, 32'hffffffff, 32'h0,
                             31'h2aaaaaaa, 31'h55555555);
        rows.push_back(row);

        keep = '{0, 0, 0, 0, 0, 0};
        foreach (rows[i]) begin
            send_pair(rows[i].pair, rows[i].typed, rows[i].want);
        end
        idle_gap(0);

        // Hold off until every pending result is back
        wait (exchange_q.size() == 0);
        @(posedge i_clk);

        // Random pairs in bursts
        for (int n = 0; n < RANDOM_PAIRS; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < RANDOM_PAIRS; b++, n++) begin
                send_pair(rand_pair(), 1'b0, keep);
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
            if (n > RANDOM_PAIRS / 2 && n < RANDOM_PAIRS / 2 + 40) begin
                idle_gap(0);
                wait (exchange_q.size() == 0);
            end
        end
        idle_gap(0);
        stim_done = 1'b1;
    end

    // Receiver stalls in a pattern of runs
    initial begin
        int run;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            run = $urandom_range(1, 30);
            res_if.ready <= ($urandom_range(0, 3) != 0);
            repeat (run) @(posedge i_clk);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_exchange e;
        t_exchange t;
        bit        typed;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (exchange_q.size() == 0) begin
                $display("%0t unexpected result exp none got hit=%0b", $time, res_if.hit);
                fail_count++;
            end else begin
                e = exchange_q.pop_front();
                t = typed_q.pop_front();
                typed = typed_flag_q.pop_front();
                if (typed && e != t) begin
                    $display("%0t typed answer exp %h predicted %h", $time, t, e);
                    fail_count++;
                end
                if (res_if.hit !== e.hit) begin
                    $display("%0t hit exp %0b got %0b", $time, e.hit, res_if.hit);
                    fail_count++;
                end
                if (res_if.degenerate !== e.degen) begin
                    $display("%0t degenerate exp %0b got %0b", $time, e.degen,
                             res_if.degenerate);
                    fail_count++;
                end
                if (res_if.new_first_vel_x !== e.v1x) begin
                    $display("%0t v1x exp %h got %h", $time, e.v1x, res_if.new_first_vel_x);
                    fail_count++;
                end
                if (res_if.new_first_vel_y !== e.v1y) begin
                    $display("%0t v1y exp %h got %h", $time, e.v1y, res_if.new_first_vel_y);
                    fail_count++;
                end
                if (res_if.new_second_vel_x !== e.v2x) begin
                    $display("%0t v2x exp %h got %h", $time, e.v2x,
                             res_if.new_second_vel_x);
                    fail_count++;
                end
                if (res_if.new_second_vel_y !== e.v2y) begin
                    $display("%0t v2y exp %h got %h", $time, e.v2y,
                             res_if.new_second_vel_y);
                    fail_count++;
                end
            end
        end
    end

    // Finish on drain, or on the cycle limit
    initial begin
        fail_count  = 0;
        cycle_count = 0;
        fork
            begin
                wait (stim_done);
                wait (exchange_q.size() == 0);
                repeat (LATENCY) @(posedge i_clk);
            end
            begin
                while (cycle_count < CYCLE_LIMIT) begin
                    @(posedge i_clk);
                    cycle_count++;
                end
                fail_count++;
                $display("%0t timeout with %0d results pending", $time, exchange_q.size());
            end
        join_any
        if (fail_count == 0) begin
            $display("[disc_collision_velocity_exchange_top] OK");
        end else begin
            $display("[disc_collision_velocity_exchange_top] ERROR");
        end
        $finish;
    end

endmodule

### disc_collision_velocity_exchange_top.f
src/dcve_pkg.sv
src/dcve_if.sv
src/dcve_front.sv
src/dcve_div.sv
src/dcve_back.sv
src/disc_collision_velocity_exchange_top.sv
test/disc_collision_velocity_exchange_top_tb.sv
